FILE: rtl/core/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

   localparam int DEPTH_DEFAULT  = 8;
   localparam int PRIORITY_WIDTH = 16;
   localparam int PAYLOAD_WIDTH  = 32;
   localparam int COUNT_WIDTH    = 4;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_REMOVE = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      kind_type                  kind;
      logic [PRIORITY_WIDTH-1:0] new_priority;
      logic [PAYLOAD_WIDTH-1:0]  new_payload;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic [PRIORITY_WIDTH-1:0] head_priority;
      logic [PAYLOAD_WIDTH-1:0]  head_payload;
      logic [COUNT_WIDTH-1:0]    entry_count;
   } rsp_type;

   typedef struct packed {
      logic [PRIORITY_WIDTH-1:0] priority_val;
      logic [PAYLOAD_WIDTH-1:0]  payload;
   } entry_type;

   typedef struct packed {
      logic                      insert;
      logic                      remove;
      logic [PRIORITY_WIDTH-1:0] new_priority;
      logic [PAYLOAD_WIDTH-1:0]  new_payload;
   } cmd_type;

endpackage

FILE: rtl/core/spq_cell.sv
// One slot of the sorted queue with its insert and shift logic.
module spq_cell (
   input  logic               clock,
   input  spq_pkg::cmd_type   cmd,
   input  logic               live,
   input  spq_pkg::entry_type left_entry,
   input  logic               left_ge,
   input  spq_pkg::entry_type right_entry,
   output spq_pkg::entry_type entry,
   output logic               ge
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   assign ge = live && (entry_ff.priority_val >= cmd.new_priority);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert && !ge) begin
         if (left_ge) begin
            entry_in.priority_val = cmd.new_priority;
            entry_in.payload      = cmd.new_payload;
         end else begin
            entry_in = left_entry;
         end
      end else if (cmd.remove) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

FILE: rtl/core/sorted_priority_queue.sv
// Top level of the sorted priority queue built from a chain of slot cells.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_ready  spq_pkg::req_type
//   rsp      out        rsp_valid/rsp_ready  spq_pkg::rsp_type
//
// All slots compare and shift in parallel on each accepted request.
// The response is registered and appears the cycle after acceptance.
// A new request is taken while the held response is being taken.
// Reset clears the entry count and the response valid flag.
// A stalled response holds req_ready low until rsp_ready returns.
module sorted_priority_queue #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spq_pkg::rsp_type rsp_data
);
   import spq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_data_ff;
   rsp_type          rsp_data_in;

   cmd_type   cmd;
   entry_type entry_w [DEPTH];
   logic      ge_w    [DEPTH];
   logic      live_w  [DEPTH];
   logic      accept;
   logic      is_full;
   logic      is_empty;
   logic [CNT_W+COUNT_WIDTH-1:0] count_ext;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign is_empty  = (count_ff == '0);

   always_comb begin
      cmd.insert       = accept && (req_data.kind == KIND_INSERT) && !is_full;
      cmd.remove       = accept && (req_data.kind == KIND_REMOVE) && !is_empty;
      cmd.new_priority = req_data.new_priority;
      cmd.new_payload  = req_data.new_payload;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign live_w[i] = (count_ff > CNT_W'(i));
      if (i == 0) begin : g_head
         spq_cell u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .live        (live_w[i]),
            .left_entry  (entry_w[i]),
            .left_ge     (1'b1),
            .right_entry (entry_w[i+1]),
            .entry       (entry_w[i]),
            .ge          (ge_w[i])
         );
      end else if (i == DEPTH - 1) begin : g_tail
         spq_cell u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .live        (live_w[i]),
            .left_entry  (entry_w[i-1]),
            .left_ge     (ge_w[i-1]),
            .right_entry (entry_w[i]),
            .entry       (entry_w[i]),
            .ge          (ge_w[i])
         );
      end else begin : g_mid
         spq_cell u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .live        (live_w[i]),
            .left_entry  (entry_w[i-1]),
            .left_ge     (ge_w[i-1]),
            .right_entry (entry_w[i+1]),
            .entry       (entry_w[i]),
            .ge          (ge_w[i])
         );
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.remove) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign count_ext = {{COUNT_WIDTH{1'b0}}, count_in};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.status        = ST_DONE;
         rsp_data_in.head_priority = '0;
         rsp_data_in.head_payload  = '0;
         rsp_data_in.entry_count   = count_ext[COUNT_WIDTH-1:0];
         if (req_data.kind == KIND_INSERT) begin
            if (is_full) begin
               rsp_data_in.status = ST_FULL;
            end
         end else if (is_empty) begin
            rsp_data_in.status = ST_EMPTY;
         end else begin
            rsp_data_in.head_priority = entry_w[0].priority_val;
            rsp_data_in.head_payload  = entry_w[0].payload;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/core/spq_checker.sv
// Port-level checker for the sorted priority queue and its bind statement.
module spq_checker #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input spq_pkg::rsp_type rsp_data
);
   import spq_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(DEPTH);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Response valid after reset.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled response changed.");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("Request taken while response stalled.");

   a_reject_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_data.status == ST_EMPTY && rsp_data.entry_count != '0) ||
                    (rsp_data.status == ST_FULL && rsp_data.entry_count != FULL_COUNT))
      |-> 1'b0)
      else $error("Rejected request reports wrong entry count.");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_DONE |->
      rsp_data.head_priority == '0 && rsp_data.head_payload == '0)
      else $error("Rejected request reports a head entry.");

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);
